>>> design/fpc_pkg.sv
package fpc_pkg;

  localparam int MIN_GAP_DEF = 200;

  localparam int XW    = 10;
  localparam int YW    = 16;
  localparam int PW    = 48;
  localparam int DIV_W = 48;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [CFG_AW-1:0] {
    CFG_REF_TEMP_0 = 3'd0,
    CFG_REF_TEMP_1 = 3'd1,
    CFG_REF_TEMP_2 = 3'd2,
    CFG_REF_TEMP_3 = 3'd3,
    CFG_MAX_TEMP   = 3'd4
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OPER_PRELOAD = 1'b0,
    OPER_RECORD  = 1'b1
  } oper_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SUM_XY, OP_SUM_XX, OP_SUM_ACC, OP_D0, OP_D1, OP_D2,
    OP_A1, OP_A2, OP_DEN, OP_F0, OP_F1, OP_F2, OP_DIV_INIT, OP_DIV_STEP,
    OP_WRITE, OP_CLAMP, OP_SP_LOAD, OP_FWD0, OP_FWD1, OP_FWD2, OP_TCLAMP,
    OP_BWD3, OP_BWD2, OP_BWD1, OP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SUM_XY, S_SUM_XX, S_SUM_ACC, S_CHK, S_D1, S_D2, S_A1, S_A2,
    S_DEN, S_FCHK, S_F1, S_F2, S_DIV_INIT, S_DIV, S_WRITE, S_CLAMP,
    S_SP_LOAD, S_FWD0, S_FWD1, S_FWD2, S_TCLAMP, S_BWD3, S_BWD2, S_BWD1, S_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
    logic       fit_done;
    logic       fit_degen;
  } fpc_cmd_t;

  typedef struct packed {
    logic       n_lt2;
    logic       d_le0;
    logic       num_neg;
    logic [3:0] marked;
  } fpc_stat_t;

endpackage

>>> design/fpc_dpath.sv
module fpc_dpath #(
  parameter int MIN_GAP = fpc_pkg::MIN_GAP_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpc_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [fpc_pkg::CFG_DW-1:0]      cfg_wdata_i,
  input  logic                            in_op_i,
  input  logic [1:0]                      in_idx_i,
  input  logic [15:0]                     in_reading_i,
  input  fpc_pkg::fpc_cmd_t               cmd_i,
  output fpc_pkg::fpc_stat_t              stat_o,
  output logic [fpc_pkg::OUT_TDATA_W-1:0] out_data_o
);

  localparam logic [17:0] GAP18 = 18'(MIN_GAP);

  logic [9:0]  ref_temp_q [4];
  logic [15:0] max_temp_q;
  logic [15:0] pv_q [4];
  logic [3:0]  mk_q;

  logic [2:0]  n_q;
  logic [11:0] sx_q;
  logic [17:0] sy_q;
  logic [28:0] sxy_q;
  logic [21:0] sx2_q;
  logic signed [47:0] prod_q, t0_q, num_q;
  logic signed [25:0] d_q;
  logic signed [32:0] a_q;
  logic [27:0] den_q;
  logic [28:0] rem_q;
  logic [47:0] dq_q;
  logic [15:0] tip_q [4];
  logic [fpc_pkg::OUT_TDATA_W-1:0] out_q;

  logic [9:0]  x_sel;
  logic [15:0] y_sel;
  logic [12:0] nx;
  logic signed [13:0] fx;
  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [58:0] prod_full;
  logic [29:0] div_tmp;
  logic [28:0] div_v;
  logic        div_ge;
  logic [28:0] rem_n;
  logic [15:0] q16;
  logic [15:0] wval;
  logic [15:0] pv3_clamp;

  function automatic logic [15:0] min16(input logic [15:0] v, input logic [15:0] top);
    min16 = (v > top) ? top : v;
  endfunction

  function automatic logic [15:0] fwd_fix(input logic [15:0] lo, input logic [15:0] hi);
    logic signed [17:0] diff;
    logic [17:0]        sum;
    diff = $signed({2'b00, hi}) - $signed({2'b00, lo});
    sum  = {2'b00, lo} + GAP18;
    if (diff < $signed(GAP18)) begin
      fwd_fix = (sum > 18'd65535) ? 16'hFFFF : sum[15:0];
    end else begin
      fwd_fix = hi;
    end
  endfunction

  function automatic logic [15:0] bwd_fix(input logic [15:0] hi, input logic [15:0] lo);
    logic signed [17:0] diff;
    logic signed [17:0] v;
    diff = $signed({2'b00, hi}) - $signed({2'b00, lo});
    v    = $signed({2'b00, hi}) - $signed(GAP18);
    if (diff < $signed(GAP18)) begin
      bwd_fix = v[17] ? 16'd0 : v[15:0];
    end else begin
      bwd_fix = lo;
    end
  endfunction

  assign x_sel = ref_temp_q[cmd_i.idx];
  assign y_sel = pv_q[cmd_i.idx];
  assign nx    = 13'(n_q) * 13'(x_sel);
  assign fx    = $signed({1'b0, nx}) - $signed({2'b00, sx_q});

  // One shared multiplier; each product is registered before use.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      fpc_pkg::OP_SUM_XY: begin mul_a = 33'(y_sel);  mul_b = 26'(x_sel); end
      fpc_pkg::OP_SUM_XX: begin mul_a = 33'(x_sel);  mul_b = 26'(x_sel); end
      fpc_pkg::OP_D0:     begin mul_a = 33'(sx2_q);  mul_b = 26'(n_q);   end
      fpc_pkg::OP_D1:     begin mul_a = 33'(sx_q);   mul_b = 26'(sx_q);  end
      fpc_pkg::OP_D2:     begin mul_a = 33'(sxy_q);  mul_b = 26'(n_q);   end
      fpc_pkg::OP_A1:     begin mul_a = 33'(sy_q);   mul_b = 26'(sx_q);  end
      fpc_pkg::OP_A2:     begin mul_a = 33'(d_q);    mul_b = 26'(n_q);   end
      fpc_pkg::OP_F0:     begin mul_a = a_q;         mul_b = 26'(fx);    end
      fpc_pkg::OP_F1:     begin mul_a = 33'(sy_q);   mul_b = d_q;        end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  assign div_v   = {den_q, 1'b0};
  assign div_tmp = {rem_q, dq_q[47]};
  assign div_ge  = div_tmp >= {1'b0, div_v};
  assign rem_n   = div_ge ? 29'(div_tmp - {1'b0, div_v}) : div_tmp[28:0];

  assign q16       = (|dq_q[47:16]) ? 16'hFFFF : dq_q[15:0];
  assign wval      = num_q[47] ? 16'd0 : q16;
  assign pv3_clamp = min16(pv_q[3], max_temp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_temp_q[0] <= 10'd200;
      ref_temp_q[1] <= 10'd266;
      ref_temp_q[2] <= 10'd333;
      ref_temp_q[3] <= 10'd400;
      max_temp_q    <= 16'd4095;
      pv_q[0]       <= '0;
      pv_q[1]       <= '0;
      pv_q[2]       <= '0;
      pv_q[3]       <= '0;
      mk_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          fpc_pkg::CFG_REF_TEMP_0: ref_temp_q[0] <= cfg_wdata_i[9:0];
          fpc_pkg::CFG_REF_TEMP_1: ref_temp_q[1] <= cfg_wdata_i[9:0];
          fpc_pkg::CFG_REF_TEMP_2: ref_temp_q[2] <= cfg_wdata_i[9:0];
          fpc_pkg::CFG_REF_TEMP_3: ref_temp_q[3] <= cfg_wdata_i[9:0];
          fpc_pkg::CFG_MAX_TEMP:   max_temp_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        fpc_pkg::OP_LOAD: begin
          pv_q[in_idx_i] <= in_reading_i;
          mk_q[in_idx_i] <= (in_op_i == fpc_pkg::OPER_RECORD);
        end
        fpc_pkg::OP_WRITE: pv_q[cmd_i.idx] <= wval;
        fpc_pkg::OP_CLAMP: pv_q[3] <= pv3_clamp;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      fpc_pkg::OP_LOAD: begin
        n_q   <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxy_q <= '0;
        sx2_q <= '0;
      end
      fpc_pkg::OP_SUM_XY: prod_q <= prod_full[47:0];
      fpc_pkg::OP_SUM_XX: begin
        if (mk_q[cmd_i.idx]) begin
          sxy_q <= sxy_q + prod_q[28:0];
        end
        prod_q <= prod_full[47:0];
      end
      fpc_pkg::OP_SUM_ACC: begin
        if (mk_q[cmd_i.idx]) begin
          sx2_q <= sx2_q + prod_q[21:0];
          n_q   <= n_q + 3'd1;
          sx_q  <= sx_q + 12'(x_sel);
          sy_q  <= sy_q + 18'(y_sel);
        end
      end
      fpc_pkg::OP_D0: prod_q <= prod_full[47:0];
      fpc_pkg::OP_D1: begin
        t0_q   <= prod_q;
        prod_q <= prod_full[47:0];
      end
      fpc_pkg::OP_D2: begin
        d_q    <= 26'(t0_q - prod_q);
        prod_q <= prod_full[47:0];
      end
      fpc_pkg::OP_A1: begin
        t0_q   <= prod_q;
        prod_q <= prod_full[47:0];
      end
      fpc_pkg::OP_A2: begin
        a_q    <= 33'(t0_q - prod_q);
        prod_q <= prod_full[47:0];
      end
      fpc_pkg::OP_DEN: den_q <= prod_q[27:0];
      fpc_pkg::OP_F0:  prod_q <= prod_full[47:0];
      fpc_pkg::OP_F1: begin
        t0_q   <= prod_q;
        prod_q <= prod_full[47:0];
      end
      fpc_pkg::OP_F2: num_q <= t0_q + prod_q;
      fpc_pkg::OP_DIV_INIT: begin
        // Rounding half away from zero: (2*num + den) / (2*den).
        rem_q <= '0;
        dq_q  <= {num_q[46:0], 1'b0} + 48'(den_q);
      end
      fpc_pkg::OP_DIV_STEP: begin
        rem_q <= rem_n;
        dq_q  <= {dq_q[46:0], div_ge};
      end
      fpc_pkg::OP_SP_LOAD: begin
        tip_q[0] <= pv_q[0];
        tip_q[1] <= pv_q[1];
        tip_q[2] <= pv_q[2];
        tip_q[3] <= pv3_clamp;
      end
      fpc_pkg::OP_FWD0:   tip_q[1] <= fwd_fix(tip_q[0], tip_q[1]);
      fpc_pkg::OP_FWD1:   tip_q[2] <= fwd_fix(tip_q[1], tip_q[2]);
      fpc_pkg::OP_FWD2:   tip_q[3] <= fwd_fix(tip_q[2], tip_q[3]);
      fpc_pkg::OP_TCLAMP: tip_q[3] <= min16(tip_q[3], max_temp_q);
      fpc_pkg::OP_BWD3:   tip_q[2] <= bwd_fix(tip_q[3], tip_q[2]);
      fpc_pkg::OP_BWD2:   tip_q[1] <= bwd_fix(tip_q[2], tip_q[1]);
      fpc_pkg::OP_BWD1:   tip_q[0] <= bwd_fix(tip_q[1], tip_q[0]);
      fpc_pkg::OP_OUT: begin
        out_q <= {6'b0, cmd_i.fit_degen, cmd_i.fit_done,
                  tip_q[3], tip_q[2], tip_q[1], tip_q[0]};
      end
      default: ;
    endcase
  end

  assign stat_o.n_lt2   = n_q < 3'd2;
  assign stat_o.d_le0   = d_q[25] || (d_q == '0);
  assign stat_o.num_neg = num_q[47];
  assign stat_o.marked  = mk_q;
  assign out_data_o     = out_q;

endmodule

>>> design/fpc_ctrl.sv
module fpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_op_i,
  input  logic [1:0]         s_idx_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  input  fpc_pkg::fpc_stat_t stat_i,
  output fpc_pkg::fpc_cmd_t  cmd_o
);

  fpc_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]                 idx_q, idx_d;
  logic [1:0]                 start_q, start_d;
  logic [fpc_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic                       degen_q, degen_d;
  logic                       ovalid_q, ovalid_d;
  logic                       s_acc;
  logic                       out_free;

  assign s_tready_o = (state_q == fpc_pkg::S_IDLE);
  assign s_acc      = s_tvalid_i && s_tready_o;
  assign out_free   = !ovalid_q || m_tready_i;
  assign m_tvalid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    start_d  = start_q;
    cnt_d    = cnt_q;
    done_d   = done_q;
    degen_d  = degen_q;
    ovalid_d = ovalid_q && !m_tready_i;
    case (state_q)
      fpc_pkg::S_IDLE: begin
        if (s_acc) begin
          idx_d   = '0;
          start_d = s_idx_i;
          done_d  = 1'b0;
          degen_d = 1'b0;
          state_d = (s_op_i == fpc_pkg::OPER_RECORD) ? fpc_pkg::S_SUM_XY
                                                    : fpc_pkg::S_SP_LOAD;
        end
      end
      fpc_pkg::S_SUM_XY: state_d = fpc_pkg::S_SUM_XX;
      fpc_pkg::S_SUM_XX: state_d = fpc_pkg::S_SUM_ACC;
      fpc_pkg::S_SUM_ACC: begin
        idx_d   = idx_q + 2'd1;
        state_d = (idx_q == 2'd3) ? fpc_pkg::S_CHK : fpc_pkg::S_SUM_XY;
      end
      fpc_pkg::S_CHK: state_d = stat_i.n_lt2 ? fpc_pkg::S_SP_LOAD : fpc_pkg::S_D1;
      fpc_pkg::S_D1:  state_d = fpc_pkg::S_D2;
      fpc_pkg::S_D2:  state_d = fpc_pkg::S_A1;
      fpc_pkg::S_A1: begin
        if (stat_i.d_le0) begin
          degen_d = 1'b1;
          state_d = fpc_pkg::S_SP_LOAD;
        end else begin
          state_d = fpc_pkg::S_A2;
        end
      end
      fpc_pkg::S_A2:  state_d = fpc_pkg::S_DEN;
      fpc_pkg::S_DEN: begin
        idx_d   = '0;
        state_d = fpc_pkg::S_FCHK;
      end
      fpc_pkg::S_FCHK: begin
        if (stat_i.marked[idx_q]) begin
          idx_d   = idx_q + 2'd1;
          state_d = (idx_q == 2'd3) ? fpc_pkg::S_CLAMP : fpc_pkg::S_FCHK;
        end else begin
          state_d = fpc_pkg::S_F1;
        end
      end
      fpc_pkg::S_F1: state_d = fpc_pkg::S_F2;
      fpc_pkg::S_F2: state_d = fpc_pkg::S_DIV_INIT;
      fpc_pkg::S_DIV_INIT: begin
        cnt_d   = '0;
        state_d = stat_i.num_neg ? fpc_pkg::S_WRITE : fpc_pkg::S_DIV;
      end
      fpc_pkg::S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == fpc_pkg::DIV_LAST) begin
          state_d = fpc_pkg::S_WRITE;
        end
      end
      fpc_pkg::S_WRITE: begin
        idx_d   = idx_q + 2'd1;
        state_d = (idx_q == 2'd3) ? fpc_pkg::S_CLAMP : fpc_pkg::S_FCHK;
      end
      fpc_pkg::S_CLAMP: begin
        done_d  = 1'b1;
        state_d = fpc_pkg::S_SP_LOAD;
      end
      fpc_pkg::S_SP_LOAD: begin
        case (start_q)
          2'd0:    state_d = fpc_pkg::S_FWD0;
          2'd1:    state_d = fpc_pkg::S_FWD1;
          2'd2:    state_d = fpc_pkg::S_FWD2;
          default: state_d = fpc_pkg::S_TCLAMP;
        endcase
      end
      fpc_pkg::S_FWD0:   state_d = fpc_pkg::S_FWD1;
      fpc_pkg::S_FWD1:   state_d = fpc_pkg::S_FWD2;
      fpc_pkg::S_FWD2:   state_d = fpc_pkg::S_TCLAMP;
      fpc_pkg::S_TCLAMP: state_d = fpc_pkg::S_BWD3;
      fpc_pkg::S_BWD3:   state_d = fpc_pkg::S_BWD2;
      fpc_pkg::S_BWD2:   state_d = fpc_pkg::S_BWD1;
      fpc_pkg::S_BWD1:   state_d = fpc_pkg::S_OUT;
      fpc_pkg::S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          state_d  = fpc_pkg::S_IDLE;
        end
      end
      default: state_d = fpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.idx       = idx_q;
    cmd_o.fit_done  = done_q;
    cmd_o.fit_degen = degen_q;
    case (state_q)
      fpc_pkg::S_IDLE:     cmd_o.op = s_acc ? fpc_pkg::OP_LOAD : fpc_pkg::OP_NONE;
      fpc_pkg::S_SUM_XY:   cmd_o.op = fpc_pkg::OP_SUM_XY;
      fpc_pkg::S_SUM_XX:   cmd_o.op = fpc_pkg::OP_SUM_XX;
      fpc_pkg::S_SUM_ACC:  cmd_o.op = fpc_pkg::OP_SUM_ACC;
      fpc_pkg::S_CHK:      cmd_o.op = fpc_pkg::OP_D0;
      fpc_pkg::S_D1:       cmd_o.op = fpc_pkg::OP_D1;
      fpc_pkg::S_D2:       cmd_o.op = fpc_pkg::OP_D2;
      fpc_pkg::S_A1:       cmd_o.op = stat_i.d_le0 ? fpc_pkg::OP_NONE : fpc_pkg::OP_A1;
      fpc_pkg::S_A2:       cmd_o.op = fpc_pkg::OP_A2;
      fpc_pkg::S_DEN:      cmd_o.op = fpc_pkg::OP_DEN;
      fpc_pkg::S_FCHK:     cmd_o.op = fpc_pkg::OP_F0;
      fpc_pkg::S_F1:       cmd_o.op = fpc_pkg::OP_F1;
      fpc_pkg::S_F2:       cmd_o.op = fpc_pkg::OP_F2;
      fpc_pkg::S_DIV_INIT: cmd_o.op = fpc_pkg::OP_DIV_INIT;
      fpc_pkg::S_DIV:      cmd_o.op = fpc_pkg::OP_DIV_STEP;
      fpc_pkg::S_WRITE:    cmd_o.op = fpc_pkg::OP_WRITE;
      fpc_pkg::S_CLAMP:    cmd_o.op = fpc_pkg::OP_CLAMP;
      fpc_pkg::S_SP_LOAD:  cmd_o.op = fpc_pkg::OP_SP_LOAD;
      fpc_pkg::S_FWD0:     cmd_o.op = fpc_pkg::OP_FWD0;
      fpc_pkg::S_FWD1:     cmd_o.op = fpc_pkg::OP_FWD1;
      fpc_pkg::S_FWD2:     cmd_o.op = fpc_pkg::OP_FWD2;
      fpc_pkg::S_TCLAMP:   cmd_o.op = fpc_pkg::OP_TCLAMP;
      fpc_pkg::S_BWD3:     cmd_o.op = fpc_pkg::OP_BWD3;
      fpc_pkg::S_BWD2:     cmd_o.op = fpc_pkg::OP_BWD2;
      fpc_pkg::S_BWD1:     cmd_o.op = fpc_pkg::OP_BWD1;
      fpc_pkg::S_OUT:      cmd_o.op = out_free ? fpc_pkg::OP_OUT : fpc_pkg::OP_NONE;
      default:             cmd_o.op = fpc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fpc_pkg::S_IDLE;
      idx_q    <= '0;
      start_q  <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      degen_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      degen_q  <= degen_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_preload_skips_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_op_i == fpc_pkg::OPER_PRELOAD) |=> state_q == fpc_pkg::S_SP_LOAD)
    else $error("preload did not go straight to spacing");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpc_pkg::S_DIV) && (cnt_q == fpc_pkg::DIV_LAST)
    |=> state_q == fpc_pkg::S_WRITE)
    else $error("divider did not finish after its last step");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && degen_q))
    else $error("fit done and degenerate both set");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpc_pkg::S_OUT) && out_free |=> ovalid_q && (state_q == fpc_pkg::S_IDLE))
    else $error("result not presented after completion");

endmodule

>>> design/four_point_calibration_fit.sv
// A preload item goes straight from acceptance to the spacing passes; the forward
// spacing pass starts at the item's index. A record item first sums its marked points and,
// if a line is fitted, fills each unmarked point with a 48-step restoring divider, skipped
// when that point's line value is negative, then goes through the same spacing passes.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset clears all points and marks, restores register defaults and drops tvalid.
module four_point_calibration_fit #(
  parameter int MIN_GAP = fpc_pkg::MIN_GAP_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpc_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [fpc_pkg::CFG_DW-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // point_index [1:0], reading [17:2], zero pad above
  input  logic [fpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // operation [0]
  input  logic [0:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tip_0 [15:0], tip_1 [31:16], tip_2 [47:32], tip_3 [63:48],
  // fit_done [64], fit_degenerate [65], zero pad above
  output logic [fpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  fpc_pkg::fpc_cmd_t  cmd;
  fpc_pkg::fpc_stat_t stat;

  fpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_op_i     (s_axis_tuser_i[0]),
    .s_idx_i    (s_axis_tdata_i[1:0]),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fpc_dpath #(
    .MIN_GAP (MIN_GAP)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (s_axis_tuser_i[0]),
    .in_idx_i     (s_axis_tdata_i[1:0]),
    .in_reading_i (s_axis_tdata_i[17:2]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_data_o   (m_axis_tdata_o)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int GAP = fpc_pkg::MIN_GAP_DEF;

  typedef struct {
    logic [15:0] tip [4];
    logic        done;
    logic        degen;
  } cal_res_t;

  typedef struct {
    fpc_pkg::oper_e op;
    logic [1:0]     idx;
    logic [15:0]    rd;
    bit             typed;
    logic [15:0]    tip [4];
  } cal_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [fpc_pkg::CFG_AW-1:0]      cfg_addr_i = '0;
  logic [fpc_pkg::CFG_DW-1:0]      cfg_wdata_i = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [fpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [0:0]                      s_axis_tuser_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [fpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  four_point_calibration_fit u_dut (.*);

  // Shadow copy of the block's points, marks and registers.
  logic [15:0] pt_val [4];
  bit          pt_mark [4];
  logic [9:0]  ref_t [4];
  logic [15:0] max_t;

  cal_res_t tips_q [$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Returns 0 for too few marks, 1 for applied, 2 for zero denominator.
  function automatic int fit_points();
    longint n = 0, sx = 0, sy = 0, sxy = 0, sx2 = 0;
    longint d, a, den, num, q, x, y;
    for (int i = 0; i < 4; i++) begin
      if (pt_mark[i]) begin
        x = ref_t[i];
        y = pt_val[i];
        n++; sx += x; sy += y; sxy += x * y; sx2 += x * x;
      end
    end
    if (n < 2) return 0;
    d = n * sx2 - sx * sx;
    if (d <= 0) return 2;
    a = n * sxy - sx * sy;
    den = n * d;
    for (int i = 0; i < 4; i++) begin
      if (!pt_mark[i]) begin
        num = a * (n * longint'(ref_t[i]) - sx) + sy * d;
        if (num >= 0) q = (2 * num + den) / (2 * den);
        else q = -((2 * (-num) + den) / (2 * den));
        if (q < 0) q = 0;
        if (q > 65535) q = 65535;
        pt_val[i] = q[15:0];
      end
    end
    if (pt_val[3] > max_t) pt_val[3] = max_t;
    return 1;
  endfunction

  function automatic cal_res_t calibrate(fpc_pkg::oper_e op, logic [1:0] idx,
                                         logic [15:0] rd);
    cal_res_t r;
    int fit = 0;
    int t [4];
    int v;
    pt_val[idx] = rd;
    pt_mark[idx] = (op == fpc_pkg::OPER_RECORD);
    if (op == fpc_pkg::OPER_RECORD) fit = fit_points();
    for (int i = 0; i < 4; i++) t[i] = pt_val[i];
    if (t[3] > max_t) t[3] = max_t;
    for (int i = idx; i <= 2; i++) begin
      if (t[i+1] - t[i] < GAP) begin
        v = t[i] + GAP;
        t[i+1] = (v > 65535) ? 65535 : v;
      end
    end
    if (t[3] > max_t) t[3] = max_t;
    for (int i = 3; i > 0; i--) begin
      if (t[i] - t[i-1] < GAP) begin
        v = t[i] - GAP;
        t[i-1] = (v < 0) ? 0 : v;
      end
    end
    for (int i = 0; i < 4; i++) r.tip[i] = t[i][15:0];
    r.done = (fit == 1);
    r.degen = (fit == 2);
    return r;
  endfunction

  task automatic cfg_write(fpc_pkg::cfg_reg_e addr, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    case (addr)
      fpc_pkg::CFG_REF_TEMP_0: ref_t[0] = val[9:0];
      fpc_pkg::CFG_REF_TEMP_1: ref_t[1] = val[9:0];
      fpc_pkg::CFG_REF_TEMP_2: ref_t[2] = val[9:0];
      fpc_pkg::CFG_REF_TEMP_3: ref_t[3] = val[9:0];
      fpc_pkg::CFG_MAX_TEMP:   max_t = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (tips_q.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  // Offers one item; returns after the transaction, leaving tvalid high or, at random, low for an idle gap.
  task automatic send(fpc_pkg::oper_e op, logic [1:0] idx, logic [15:0] rd, bit typed = 0,
                      cal_res_t want = '{default: '0});
    cal_res_t r;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'd0, rd, idx};
    s_axis_tuser_i <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = calibrate(op, idx, rd);
    if (typed) r = want;
    tips_q.push_back(r);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    int n;
    logic [1:0] k;
    if ($urandom_range(9) < 2) begin
      send(fpc_pkg::oper_e'($urandom_range(1)), 2'($urandom_range(3)), 16'($urandom));
    end else begin
      // A calibration run: up to two preloads, then two to four measured points.
      n = $urandom_range(2);
      repeat (n) send(fpc_pkg::OPER_PRELOAD, 2'($urandom_range(3)), 16'($urandom));
      n = $urandom_range(4, 2);
      k = 2'($urandom_range(3));
      repeat (n) begin
        send(fpc_pkg::OPER_RECORD, k, ($urandom_range(3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(4000)));
        k = k + 2'($urandom_range(3, 1));
      end
    end
  endtask

  initial begin
    cal_row_t rows [$];
    cal_res_t want;
    rows = '{
      '{fpc_pkg::OPER_PRELOAD, 2'd0, 16'd0,    1, '{16'd0, 16'd200, 16'd400, 16'd600}},
      '{fpc_pkg::OPER_PRELOAD, 2'd3, 16'hFFFF, 1, '{16'd0, 16'd0, 16'd0, 16'd4095}},
      '{fpc_pkg::OPER_PRELOAD, 2'd1, 16'hFFFF, 0, '{default: '0}},
      '{fpc_pkg::OPER_PRELOAD, 2'd2, 16'h8000, 0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd0, 16'd1000, 0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd1, 16'd1500, 0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd3, 16'd3000, 0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd2, 16'd2000, 0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd2, 16'd2100, 0, '{default: '0}},
      '{fpc_pkg::OPER_PRELOAD, 2'd0, 16'd0,    0, '{default: '0}},
      '{fpc_pkg::OPER_PRELOAD, 2'd2, 16'd0,    0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd1, 16'hFFFF, 0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd3, 16'd0,    0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd0, 16'hFFFF, 0, '{default: '0}},
      '{fpc_pkg::OPER_PRELOAD, 2'd3, 16'd5555, 0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd3, 16'hFFFF, 0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd2, 16'd0,    0, '{default: '0}},
      '{fpc_pkg::OPER_PRELOAD, 2'd1, 16'd0,    0, '{default: '0}},
      '{fpc_pkg::OPER_RECORD,  2'd1, 16'd0,    0, '{default: '0}}
    };
    for (int i = 0; i < 4; i++) begin
      pt_val[i] = '0;
      pt_mark[i] = 1'b0;
    end
    ref_t = '{10'd200, 10'd266, 10'd333, 10'd400};
    max_t = 16'd4095;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 7;
    rx_idle_pct = 53;
    foreach (rows[i]) begin
      want.tip = rows[i].tip;
      want.done = 1'b0;
      want.degen = 1'b0;
      send(rows[i].op, rows[i].idx, rows[i].rd, rows[i].typed, want);
    end

    for (int s = 0; s < 6; s++) begin
      tx_idle_pct = (s < 2) ? 7 : (s < 4) ? 53 : 0;
      rx_idle_pct = (s < 2) ? 53 : (s < 4) ? 7 : 0;
      s_axis_tvalid_i <= 1'b0;
      drain();
      case (s)
        1: begin
          cfg_write(fpc_pkg::CFG_REF_TEMP_0, 16'd0);
          cfg_write(fpc_pkg::CFG_REF_TEMP_1, 16'd0);
          cfg_write(fpc_pkg::CFG_REF_TEMP_2, 16'd0);
          cfg_write(fpc_pkg::CFG_REF_TEMP_3, 16'd0);
          cfg_write(fpc_pkg::CFG_MAX_TEMP, 16'd0);
        end
        2: begin
          cfg_write(fpc_pkg::CFG_REF_TEMP_0, 16'd0);
          cfg_write(fpc_pkg::CFG_REF_TEMP_1, 16'd341);
          cfg_write(fpc_pkg::CFG_REF_TEMP_2, 16'd682);
          cfg_write(fpc_pkg::CFG_REF_TEMP_3, 16'd1023);
          cfg_write(fpc_pkg::CFG_MAX_TEMP, 16'hFFFF);
        end
        3: begin
          want.tip[0] = 16'($urandom_range(1023));
          cfg_write(fpc_pkg::CFG_REF_TEMP_0, want.tip[0]);
          cfg_write(fpc_pkg::CFG_REF_TEMP_1, want.tip[0]);
          cfg_write(fpc_pkg::CFG_REF_TEMP_2, want.tip[0]);
          cfg_write(fpc_pkg::CFG_REF_TEMP_3, 16'($urandom_range(1023)));
          cfg_write(fpc_pkg::CFG_MAX_TEMP, 16'($urandom_range(8000)));
        end
        4, 5: begin
          // Upper bits beyond ten are written too, and must be dropped.
          cfg_write(fpc_pkg::CFG_REF_TEMP_0, 16'($urandom));
          cfg_write(fpc_pkg::CFG_REF_TEMP_1, 16'($urandom));
          cfg_write(fpc_pkg::CFG_REF_TEMP_2, 16'($urandom));
          cfg_write(fpc_pkg::CFG_REF_TEMP_3, 16'($urandom));
          cfg_write(fpc_pkg::CFG_MAX_TEMP,
                    (s == 4) ? 16'($urandom) : 16'($urandom_range(6000)));
        end
        default: ;
      endcase
      for (int k = 0; k < 36; k++) begin
        if (k == 10) hold_req = 1'b1;
        if (k == 25) begin
          s_axis_tvalid_i <= 1'b0;
          wait (tips_q.size() == 0);
          @(posedge clk_i);
        end
        send_random();
      end
    end
    s_axis_tvalid_i <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    cal_res_t w;
    int hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (tips_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          w = tips_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (m_axis_tdata_o[16*i +: 16] !== w.tip[i])
              report($sformatf("tip_%0d", i), m_axis_tdata_o[16*i +: 16], w.tip[i]);
          end
          if (m_axis_tdata_o[64] !== w.done) report("fit_done", m_axis_tdata_o[64], w.done);
          if (m_axis_tdata_o[65] !== w.degen)
            report("fit_degenerate", m_axis_tdata_o[65], w.degen);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

endmodule
